### hw/rtl/scr_pkg.sv
// Shared constants and types for the segment cache clock replacement unit.
package scr_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int PAGE_W       = 32;
  localparam int SLOT_W       = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int STEP_W       = CNT_W + 1;
  localparam int PIN_W        = 15;
  localparam int STATUS_W     = 3;
  localparam int SEG_BITS_W   = 5;
  localparam int LIMIT_W      = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_BITS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 1'd1;

  localparam logic OP_PIN   = 1'b0;
  localparam logic OP_UNPIN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICTED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNPIN_DONE = 3'd4;

  typedef struct packed {
    logic             clock;
    logic [PIN_W-1:0] pins;
  } meta_t;

endpackage

### hw/rtl/segment_cache_clock_replace_unit.sv
// Segment cache with clock replacement: lookup, fill and eviction sequencer.
//
//  channel  | ports                                           | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid, in_stall, in_operation, in_page_id,   | in
//           | in_entry_slot                                   |
//  result   | out_valid, out_stall, out_slot, out_status,     | out
//           | out_evicted_base                                |
//  config   | cfg_wr_en, cfg_index, cfg_wr_data               | in
//
// One item at a time. Each entry visit uses the single entry memory port:
// address first, then compare/update on the registered read data.
// Reset is synchronous; no memory clearing pass, used_count bounds reads.
// A stalled result holds in the output register; the sequencer waits.
module segment_cache_clock_replace_unit
  import scr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [PAGE_W-1:0]     in_page_id,
  input  logic [SLOT_W-1:0]     in_entry_slot,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PAGE_W-1:0]     out_evicted_base,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UNPIN   = 4'd1;
  localparam logic [3:0] S_LK_ADDR = 4'd2;
  localparam logic [3:0] S_LK_EVAL = 4'd3;
  localparam logic [3:0] S_MISS    = 4'd4;
  localparam logic [3:0] S_SW_ADDR = 4'd5;
  localparam logic [3:0] S_SW_EVAL = 4'd6;
  localparam logic [3:0] S_RESP    = 4'd7;

  // config registers
  logic [SEG_BITS_W-1:0] seg_bits_r;
  logic [LIMIT_W-1:0]    pool_limit_r;

  // sequencer state
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  used_count_r, used_count_nxt;
  logic [SLOT_W-1:0] hand_r, hand_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;

  // item being worked on
  logic [PAGE_W-1:0] base_r, base_nxt;
  logic [SLOT_W-1:0] eslot_r, eslot_nxt;

  // pending result
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [PAGE_W-1:0]   res_evict_r, res_evict_nxt;

  // output register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGE_W-1:0]   out_evict_r;

  // entry memories
  logic [PAGE_W-1:0] base_mem [POOL_ENTRIES];
  meta_t             meta_mem [POOL_ENTRIES];
  logic [PAGE_W-1:0] base_rd_r;
  meta_t             meta_rd_r;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              base_we, meta_we;
  logic [PAGE_W-1:0] base_wdata;
  meta_t             meta_wdata;

  logic [CNT_W-1:0]  lim;
  logic [STEP_W-1:0] lim2;
  logic [PAGE_W-1:0] in_base;
  logic              in_xfer, out_free;
  logic [SLOT_W-1:0] hand_start, hand_step;

  // limit in effect, clamped to 2..POOL_ENTRIES
  always_comb begin
    if (pool_limit_r < LIMIT_W'(2)) begin
      lim = CNT_W'(2);
    end else if (pool_limit_r > LIMIT_W'(POOL_ENTRIES)) begin
      lim = CNT_W'(POOL_ENTRIES);
    end else begin
      lim = CNT_W'(pool_limit_r);
    end
  end
  assign lim2 = {lim, 1'b0};

  always_comb begin
    if (int'(seg_bits_r) >= PAGE_W) begin
      in_base = '0;
    end else begin
      in_base = in_page_id & ({PAGE_W{1'b1}} << seg_bits_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // hand restarts at 0 if the limit was lowered under it
  assign hand_start = ({1'b0, hand_r} >= lim) ? '0 : hand_r;
  assign hand_step  = ((CNT_W'(hand_r) + CNT_W'(1)) >= lim) ? '0 : hand_r + SLOT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    used_count_nxt = used_count_r;
    hand_nxt       = hand_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    base_nxt       = base_r;
    eslot_nxt      = eslot_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_evict_nxt  = res_evict_r;
    rd_addr        = idx_r;
    wr_addr        = idx_r;
    base_we        = 1'b0;
    meta_we        = 1'b0;
    base_wdata     = base_r;
    meta_wdata     = meta_rd_r;

    case (state_r)
      S_IDLE: begin
        rd_addr = in_entry_slot;
        if (in_xfer) begin
          base_nxt  = in_base;
          eslot_nxt = in_entry_slot;
          idx_nxt   = SLOT_W'(1);
          if (in_operation == OP_UNPIN) begin
            state_nxt = S_UNPIN;
          end else if (used_count_r == '0) begin
            state_nxt = S_MISS;
          end else begin
            state_nxt = S_LK_ADDR;
          end
        end
      end

      S_UNPIN: begin
        wr_addr = eslot_r;
        if (eslot_r != '0 && CNT_W'(eslot_r) <= used_count_r && meta_rd_r.pins != '0) begin
          meta_we         = 1'b1;
          meta_wdata.pins = meta_rd_r.pins - PIN_W'(1);
        end
        res_slot_nxt   = eslot_r;
        res_status_nxt = ST_UNPIN_DONE;
        res_evict_nxt  = '0;
        state_nxt      = S_RESP;
      end

      S_LK_ADDR: begin
        rd_addr   = idx_r;
        state_nxt = S_LK_EVAL;
      end

      S_LK_EVAL: begin
        wr_addr = idx_r;
        if (base_rd_r == base_r) begin
          meta_we          = 1'b1;
          meta_wdata.clock = 1'b1;
          if (meta_rd_r.pins != PIN_MAX) begin
            meta_wdata.pins = meta_rd_r.pins + PIN_W'(1);
          end
          res_slot_nxt   = idx_r;
          res_status_nxt = ST_HIT;
          res_evict_nxt  = '0;
          state_nxt      = S_RESP;
        end else if (CNT_W'(idx_r) == used_count_r) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt   = idx_r + SLOT_W'(1);
          state_nxt = S_LK_ADDR;
        end
      end

      S_MISS: begin
        if ((used_count_r + CNT_W'(1)) < lim) begin
          used_count_nxt   = used_count_r + CNT_W'(1);
          wr_addr          = SLOT_W'(used_count_nxt);
          base_we          = 1'b1;
          meta_we          = 1'b1;
          meta_wdata.clock = 1'b1;
          meta_wdata.pins  = PIN_W'(1);
          res_slot_nxt     = SLOT_W'(used_count_nxt);
          res_status_nxt   = ST_NEW;
          res_evict_nxt    = '0;
          state_nxt        = S_RESP;
        end else begin
          hand_nxt  = hand_start;
          steps_nxt = '0;
          state_nxt = S_SW_ADDR;
        end
      end

      S_SW_ADDR: begin
        rd_addr = hand_r;
        if (steps_r == lim2) begin
          // two full sweeps, hand is back where it started
          res_slot_nxt   = '0;
          res_status_nxt = ST_ALL_PINNED;
          res_evict_nxt  = '0;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt   = hand_r;
          hand_nxt  = hand_step;
          steps_nxt = steps_r + STEP_W'(1);
          if (hand_r != '0) begin
            state_nxt = S_SW_EVAL;
          end
        end
      end

      S_SW_EVAL: begin
        wr_addr = idx_r;
        meta_we = 1'b1;
        if (meta_rd_r.pins != '0 || meta_rd_r.clock) begin
          meta_wdata.clock = 1'b0;
          state_nxt        = S_SW_ADDR;
        end else begin
          base_we          = 1'b1;
          meta_wdata.clock = 1'b1;
          meta_wdata.pins  = PIN_W'(1);
          res_slot_nxt     = idx_r;
          res_status_nxt   = ST_EVICTED;
          res_evict_nxt    = base_rd_r;
          state_nxt        = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // entry memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[wr_addr] <= base_wdata;
    end
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wdata;
    end
    base_rd_r <= base_mem[rd_addr];
    meta_rd_r <= meta_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_count_r <= '0;
      hand_r       <= '0;
      seg_bits_r   <= '0;
      pool_limit_r <= LIMIT_W'(POOL_ENTRIES);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      hand_r       <= hand_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEG_BITS:   seg_bits_r   <= cfg_wr_data[SEG_BITS_W-1:0];
          CFG_POOL_LIMIT: pool_limit_r <= cfg_wr_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    steps_r      <= steps_nxt;
    base_r       <= base_nxt;
    eslot_r      <= eslot_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_evict_r  <= res_evict_nxt;
    if (state_r == S_RESP && out_free) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
      out_evict_r  <= res_evict_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot         = out_slot_r;
  assign out_status       = out_status_r;
  assign out_evicted_base = out_evict_r;

endmodule

### verif/scr_checker.sv
// Checker for the segment cache clock replacement unit: predicts and compares every result.
module scr_checker
  import scr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_operation,
  input  logic [PAGE_W-1:0]     in_page_id,
  input  logic [SLOT_W-1:0]     in_entry_slot,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SLOT_W-1:0]     out_slot,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [PAGE_W-1:0]     out_evicted_base,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output int                    mismatch_count,
  output int                    results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   evicted_base;
  } access_result_t;

  // Shadow copy of the pool
  logic [PAGE_W-1:0]     seg_base [POOL_ENTRIES];
  meta_t                 entry_meta [POOL_ENTRIES];
  int unsigned           slots_used;
  int unsigned           hand;
  logic [SEG_BITS_W-1:0] seg_shift;
  logic [LIMIT_W-1:0]    limit_reg;

  access_result_t        pending_results [$];

  function automatic int unsigned limit_now();
    int unsigned lim;
    lim = limit_reg;
    if (lim < 2) lim = 2;
    if (lim > POOL_ENTRIES) lim = POOL_ENTRIES;
    return lim;
  endfunction

  function automatic logic [PAGE_W-1:0] segment_base(logic [PAGE_W-1:0] page);
    if (seg_shift >= PAGE_W) return '0;
    return page & ({PAGE_W{1'b1}} << seg_shift);
  endfunction

  function automatic access_result_t predict_access(logic op, logic [PAGE_W-1:0] page,
                                                    logic [SLOT_W-1:0] eslot);
    access_result_t   res;
    int unsigned      lim;
    int unsigned      v;
    logic [PAGE_W-1:0] base;
    res = '0;
    lim = limit_now();
    if (op == OP_UNPIN) begin
      // bad unpins (slot 0, unused slot, zero count) leave state alone
      if (eslot != 0 && eslot <= slots_used && entry_meta[eslot].pins != 0)
        entry_meta[eslot].pins = entry_meta[eslot].pins - 1'b1;
      res.slot   = eslot;
      res.status = ST_UNPIN_DONE;
      return res;
    end
    base = segment_base(page);
    // lookup covers every slot in use, even beyond a lowered limit
    for (int s = 1; s <= slots_used && s < POOL_ENTRIES; s++) begin
      if (seg_base[s] == base) begin
        entry_meta[s].clock = 1'b1;
        if (entry_meta[s].pins != PIN_MAX) entry_meta[s].pins = entry_meta[s].pins + 1'b1;
        res.slot   = SLOT_W'(s);
        res.status = ST_HIT;
        return res;
      end
    end
    if (slots_used + 1 < lim) begin
      slots_used++;
      seg_base[slots_used]   = base;
      entry_meta[slots_used] = '{clock: 1'b1, pins: PIN_W'(1)};
      res.slot   = SLOT_W'(slots_used);
      res.status = ST_NEW;
      return res;
    end
    if (hand >= lim) hand = 0;
    for (int n = 0; n < 2 * lim; n++) begin
      v    = hand;
      hand = (hand + 1 >= lim) ? 0 : hand + 1;
      if (v == 0) continue;
      if (entry_meta[v].pins != 0 || entry_meta[v].clock) begin
        entry_meta[v].clock = 1'b0;
        continue;
      end
      res.slot         = SLOT_W'(v);
      res.status       = ST_EVICTED;
      res.evicted_base = seg_base[v];
      seg_base[v]      = base;
      entry_meta[v]    = '{clock: 1'b1, pins: PIN_W'(1)};
      return res;
    end
    // two full sweeps and nothing free: hand is back where it started
    res.status = ST_ALL_PINNED;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [PAGE_W-1:0] got, logic [PAGE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] error: %s got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      foreach (entry_meta[i]) begin
        entry_meta[i] = '0;
        seg_base[i]   = '0;
      end
      slots_used     = 0;
      hand           = 0;
      seg_shift      = '0;
      limit_reg      = LIMIT_W'(POOL_ENTRIES);
      mismatch_count = 0;
      pending_results.delete();
      results_due   <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEG_BITS:   seg_shift = cfg_wr_data[SEG_BITS_W-1:0];
          CFG_POOL_LIMIT: limit_reg = cfg_wr_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never belongs to the item taken this edge
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, slot", PAGE_W'(out_slot), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_slot != want.slot)
            report_mismatch("slot", PAGE_W'(out_slot), PAGE_W'(want.slot));
          if (out_status != want.status)
            report_mismatch("status", PAGE_W'(out_status), PAGE_W'(want.status));
          if (out_evicted_base != want.evicted_base)
            report_mismatch("evicted_base", out_evicted_base, want.evicted_base);
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_access(in_operation, in_page_id, in_entry_slot));
      results_due <= pending_results.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for the segment cache clock replacement unit: stimulus, idling and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scr_pkg::*;

  localparam int         RAND_PHASES     = 10;
  localparam int         ITEMS_PER_PHASE = 172;
  localparam int         PIN_REPEAT      = 8;    // hits on slot 1 at the start
  localparam int         HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int         SETTLE_CYCLES   = 16;   // quiet time after the last result
  localparam longint     RUN_LIMIT_NS    = 100_000_000;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic                  in_operation     = OP_PIN;
  logic [PAGE_W-1:0]     in_page_id       = '0;
  logic [SLOT_W-1:0]     in_entry_slot    = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [SLOT_W-1:0]     out_slot;
  logic [STATUS_W-1:0]   out_status;
  logic [PAGE_W-1:0]     out_evicted_base;
  logic                  cfg_wr_en        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_SEG_BITS;
  logic [CFG_DATA_W-1:0] cfg_wr_data      = '0;

  int                    mismatch_count;
  int                    results_due;

  // Idle odds in percent. The sender's is only read by the stimulus process.
  int                    send_idle_pct    = 0;
  int                    recv_idle_pct    = 0;
  int                    hold_ticket      = 0;
  int                    hold_seen        = 0;
  int                    hold_left        = 0;

  segment_cache_clock_replace_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_page_id       (in_page_id),
    .in_entry_slot    (in_entry_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot         (out_slot),
    .out_status       (out_status),
    .out_evicted_base (out_evicted_base),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  scr_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_page_id       (in_page_id),
    .in_entry_slot    (in_entry_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot         (out_slot),
    .out_status       (out_status),
    .out_evicted_base (out_evicted_base),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off each time the ticket moves.
  // The hold is counted here so the sender keeps offering items meanwhile and
  // the block backs up into its input.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stall always works on the receiver's copy at the next edge.
  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // One input transfer. Valid only drops when a gap is taken, so back-to-back
  // items keep it high without a lower/raise in the same step.
  task automatic send(logic op, logic [PAGE_W-1:0] page, logic [SLOT_W-1:0] eslot);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_page_id    <= page;
    in_entry_slot <= eslot;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted result has come back.
  // The first edge lets the checker count the item taken just now.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called while the block is idle.
  task automatic program_regs(int unsigned seg, int unsigned lim);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_SEG_BITS;
    cfg_wr_data <= CFG_DATA_W'(seg);
    @(posedge clk);
    cfg_index   <= CFG_POOL_LIMIT;
    cfg_wr_data <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int unsigned       seg;
    int unsigned       lim;
    int unsigned       lim_eff;
    int unsigned       pin_pct;
    int unsigned       pick;
    int unsigned       ws_idx;
    logic [PAGE_W-1:0] salt;
    logic [PAGE_W-1:0] low_mask;
    logic [PAGE_W-1:0] page;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pin count on slot 1 at reset settings (seg_bits 0, limit 64): first pin
    // fills slot 1, a run of hits raises the count, then the unpins walk it
    // back down to zero.
    send(OP_PIN, '0, 6'h3F);
    for (int n = 0; n < PIN_REPEAT; n++) send(OP_PIN, '0, 6'h00);
    for (int n = 0; n <= PIN_REPEAT; n++) send(OP_UNPIN, $urandom, 6'h01);

    set_idling(33, 57);

    // New entries with extreme page ids, then a hit.
    send(OP_PIN, 32'hFFFF_FFFF, 6'h00);
    send(OP_PIN, 32'hAAAA_5555, 6'h2A);
    send(OP_PIN, 32'h5555_AAAA, 6'h15);
    send(OP_PIN, 32'hFFFF_FFFF, 6'h3F);
    // Bad unpins: reserved slot, slots never filled, zero count.
    send(OP_UNPIN, 32'hFFFF_FFFF, 6'h00);
    send(OP_UNPIN, 32'h0000_0000, 6'h3F);
    send(OP_UNPIN, 32'h5555_5555, 6'h2A);
    send(OP_UNPIN, 32'hAAAA_AAAA, 6'h15);
    send(OP_UNPIN, 32'h0000_0000, 6'h01);
    // Good unpins down to zero on slot 2.
    send(OP_UNPIN, 32'h0000_0000, 6'h02);
    send(OP_UNPIN, 32'h0000_0000, 6'h02);

    // Widest segments and a limit below range (clamps to 2: only slot 1 sweepable).
    settle();
    program_regs(31, 0);
    send(OP_PIN, 32'h8000_0000, 6'h00);  // clock bit cleared, then evicted
    send(OP_PIN, 32'h7FFF_FFFF, 6'h00);  // slot 1 pinned: gives up
    send(OP_UNPIN, 32'h0000_0000, 6'h01);
    send(OP_PIN, 32'h7FFF_FFFF, 6'h3F);  // evicts again
    send(OP_PIN, 32'h0000_1234, 6'h3F);  // same segment: hit

    // Random phases. Plans include the register extremes; limit 8 followed by
    // limit 3 leaves the hand out of range and in-use slots beyond the limit.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      seg = $urandom_range(31);
      lim = $urandom_range(2, 16);
      case (ph)
        0: begin seg = 0;  lim = 4;   end
        1: begin seg = 31; lim = 3;   end
        2: lim = 8;
        3: lim = 3;
        4: begin seg = 12; lim = 127; end
        5: lim = 1;
        7: begin seg = 16; lim = 64;  end
        8: lim = 5;
        default: ;
      endcase
      if (ph == 4) set_idling(57, 33);
      else if (ph == 7) set_idling(0, 0);

      settle();
      program_regs(seg, lim);
      lim_eff  = (lim < 2) ? 2 : (lim > POOL_ENTRIES) ? POOL_ENTRIES : lim;
      pin_pct  = $urandom_range(40, 65);
      salt     = $urandom;
      low_mask = (32'h1 << seg) - 1;

      // Hold the receiver while the sender streams with no gaps.
      if (ph == 8) hold_ticket <= hold_ticket + 1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Sender pause mid-phase until everything is back.
        if (ph == 9 && n == ITEMS_PER_PHASE / 2) settle();
        pick = $urandom_range(99);
        if (pick < 5) begin
          // any slot at all, including reserved and unused ones
          send(OP_UNPIN, $urandom, SLOT_W'($urandom_range(63)));
        end else if (pick < 12) begin
          send(OP_PIN, $urandom, SLOT_W'($urandom_range(63)));
        end else if ($urandom_range(99) < pin_pct) begin
          // working set about 1.5x the pool, random offset inside the segment
          ws_idx = $urandom_range(lim_eff + lim_eff / 2);
          page   = (((ws_idx << seg) ^ salt) & ~low_mask) | ($urandom & low_mask);
          send(OP_PIN, page, SLOT_W'($urandom_range(63)));
        end else begin
          send(OP_UNPIN, $urandom, SLOT_W'($urandom_range(1, lim_eff - 1)));
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
